/* rtl/core/base64_stream_decoder_core_assert.svh */
// assertion macros for the base64 stream decoder
// included by the rtl modules that carry concurrent checks, no other dependencies
`ifndef BASE64_STREAM_DECODER_CORE_ASSERT_SVH
`define BASE64_STREAM_DECODER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// check under clock, disabled while reset is asserted (active low)
`define B64D_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("b64d assertion failed");
// check under clock, also active during reset
`define B64D_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("b64d assertion failed");
`else
`define B64D_ASSERT(lbl, clk, rstn, prop)
`define B64D_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/core/b64d_pkg.sv */
// shared types, constants and the character decode function of the base64 decoder
// no dependencies
`default_nettype none

package b64d_pkg;

    localparam int CHAR_W      = 8;
    localparam int SEXTET_W    = 6;
    localparam int BUF_W       = 3 * SEXTET_W;
    localparam int WORD_W      = 4 * SEXTET_W;
    localparam int GROUP_DEPTH = 4;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_PAD     = 8'h3D;

    localparam logic [CHAR_W-1:0]   LOWER_BASE = 8'd26;
    localparam logic [CHAR_W-1:0]   DIGIT_BASE = 8'd52;
    localparam logic [SEXTET_W-1:0] PLUS_VAL   = 6'd62;
    localparam logic [SEXTET_W-1:0] SLASH_VAL  = 6'd63;
    localparam logic [SEXTET_W-1:0] PAD_VAL    = 6'd0;

    // last byte index inside a group
    localparam logic [1:0] LAST_IDX_ONE   = 2'd0;
    localparam logic [1:0] LAST_IDX_TWO   = 2'd1;
    localparam logic [1:0] LAST_IDX_THREE = 2'd2;

    typedef struct packed {
        logic                is_sym;
        logic                is_pad;
        logic [SEXTET_W-1:0] val;
    } sextet_t;

    // one group of results caused by one input item
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [1:0]        last_idx;
        logic              is_status;
        logic              failed;
    } group_t;

    function automatic sextet_t sextet_of(input logic [CHAR_W-1:0] ch);
        sextet_t s;
        s = '{is_sym: 1'b1, is_pad: 1'b0, val: PAD_VAL};
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            s.val = SEXTET_W'(ch - CH_UPPER_A);
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            s.val = SEXTET_W'(ch - CH_LOWER_A + LOWER_BASE);
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            s.val = SEXTET_W'(ch - CH_DIGIT_0 + DIGIT_BASE);
        end else if (ch == CH_PLUS) begin
            s.val = PLUS_VAL;
        end else if (ch == CH_SLASH) begin
            s.val = SLASH_VAL;
        end else if (ch == CH_PAD) begin
            s.is_pad = 1'b1;
        end else begin
            s.is_sym = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/b64d_quad.sv */
// input register, quad assembly state and result group builder
// depends on b64d_pkg
`default_nettype none

module b64d_quad
    import b64d_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CHAR_W-1:0] s_text_char,
    input  wire logic              s_end_of_text,
    input  wire logic              push_ok,
    output logic                   grp_push,
    output group_t                 grp
);

    logic              valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              end_reg;

    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [1:0]       pos_reg, pos_next;
    logic             third_reg, third_next;
    logic             closed_reg, closed_next;
    logic             err_reg, err_next;

    sextet_t sx;
    logic    produces;
    logic    fire;

    assign sx = sextet_of(char_reg);

    always_comb begin
        buf_next    = buf_reg;
        pos_next    = pos_reg;
        third_next  = third_reg;
        closed_next = closed_reg;
        err_next    = err_reg;
        produces    = 1'b0;
        grp         = '0;
        if (end_reg) begin
            produces      = 1'b1;
            grp.is_status = 1'b1;
            grp.failed    = err_reg || (pos_reg != 2'd0);
            grp.last_idx  = LAST_IDX_ONE;
            buf_next      = '0;
            pos_next      = '0;
            third_next    = 1'b0;
            closed_next   = 1'b0;
            err_next      = 1'b0;
        end else if (!err_reg && sx.is_sym) begin
            if (closed_reg) begin
                err_next = 1'b1;
            end else begin
                case (pos_reg)
                    2'd0, 2'd1: begin
                        if (sx.is_pad) begin
                            err_next = 1'b1;
                        end else begin
                            buf_next = {buf_reg[BUF_W-SEXTET_W-1:0], sx.val};
                            pos_next = pos_reg + 2'd1;
                        end
                    end
                    2'd2: begin
                        if (sx.is_pad) begin
                            third_next = 1'b1;
                        end
                        buf_next = {buf_reg[BUF_W-SEXTET_W-1:0], sx.val};
                        pos_next = 2'd3;
                    end
                    default: begin
                        if (third_reg && !sx.is_pad) begin
                            err_next = 1'b1;
                        end else begin
                            produces = 1'b1;
                            grp.word = {buf_reg, sx.val};
                            if (third_reg) begin
                                grp.last_idx = LAST_IDX_ONE;
                            end else if (sx.is_pad) begin
                                grp.last_idx = LAST_IDX_TWO;
                            end else begin
                                grp.last_idx = LAST_IDX_THREE;
                            end
                            closed_next = closed_reg || third_reg || sx.is_pad;
                            buf_next    = '0;
                            pos_next    = '0;
                            third_next  = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    // an item that yields nothing never waits on the result queue
    assign fire     = valid_reg && (!produces || push_ok);
    assign grp_push = fire && produces;
    assign s_ready  = !valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            char_reg <= s_text_char;
            end_reg  <= s_end_of_text;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg    <= '0;
            pos_reg    <= '0;
            third_reg  <= 1'b0;
            closed_reg <= 1'b0;
            err_reg    <= 1'b0;
        end else if (fire) begin
            buf_reg    <= buf_next;
            pos_reg    <= pos_next;
            third_reg  <= third_next;
            closed_reg <= closed_next;
            err_reg    <= err_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/b64d_out.sv */
// result group queue and byte serializer on the result channel
// depends on b64d_pkg and base64_stream_decoder_core_assert.svh
`default_nettype none
`include "base64_stream_decoder_core_assert.svh"

module b64d_out
    import b64d_pkg::*;
#(
    parameter int DEPTH = GROUP_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              grp_push,
    input  group_t                 grp,
    output logic                   push_ok,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CHAR_W-1:0]      m_data_byte,
    output logic                   m_is_status,
    output logic                   m_failed,
    output logic                   m_last_of_run
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]       sub_reg;

    group_t head;
    logic   out_fire;
    logic   pop;

    assign head     = mem[rd_ptr_reg];
    assign push_ok  = count_reg != CNT_W'(DEPTH);
    assign m_valid  = count_reg != '0;
    assign out_fire = m_valid && m_ready;
    assign pop      = out_fire && (sub_reg == head.last_idx);

    assign m_is_status   = head.is_status;
    assign m_failed      = head.failed;
    assign m_last_of_run = sub_reg == head.last_idx;

    always_comb begin
        case (sub_reg)
            2'd0:    m_data_byte = head.word[WORD_W-1 -: CHAR_W];
            2'd1:    m_data_byte = head.word[WORD_W-CHAR_W-1 -: CHAR_W];
            default: m_data_byte = head.word[CHAR_W-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (grp_push) begin
            mem[wr_ptr_reg] <= grp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= '0;
        end else begin
            if (grp_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                sub_reg    <= '0;
            end else if (out_fire) begin
                sub_reg <= sub_reg + 2'd1;
            end
            if (grp_push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !grp_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `B64D_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `B64D_ASSERT(a_sub_in_group, aclk, aresetn, m_valid |-> sub_reg <= head.last_idx)
    `B64D_ASSERT(a_sub_idle, aclk, aresetn, !m_valid |-> sub_reg == 2'd0)
    `B64D_ASSERT(a_pop_count, aclk, aresetn, (pop && !grp_push) |=> count_reg == $past(count_reg) - 1'b1)

endmodule

`default_nettype wire

/* rtl/core/base64_stream_decoder_core.sv */
// top level of the streaming base64 decoder
// depends on b64d_pkg, b64d_quad and b64d_out
//
// usage
//   input channel s_*: one transfer per text character, or an end marker with
//   s_end_of_text high (s_text_char is then ignored). characters outside the
//   base64 alphabet and other than '=' are dropped without a result.
//   result channel m_*: every fourth kept symbol releases up to three decoded
//   bytes, one transfer each; an end marker releases one status transfer with
//   m_is_status high and m_failed telling whether the whole string was bad.
//   m_last_of_run marks the last transfer caused by one input item. on a failed
//   status the receiver throws away every byte of that string.
// timing
//   an accepted item is registered in the input register; its result group is
//   then written into the result queue, and its first result is presented from
//   the queue head. the result queue holds GROUP_DEPTH_P groups (four by default)
//   and is drained one byte per cycle, so one character per cycle is sustained
//   as long as the receiver keeps m_ready high (three bytes per four symbols).
// reset and stall
//   aresetn is synchronous, active low, and clears the quad state, the sticky
//   error and the queue. when the receiver stalls the queue fills; the input
//   stage then holds only items that would add a group, skipped characters and
//   non-completing symbols still flow in.
`default_nettype none

module base64_stream_decoder_core
    import b64d_pkg::*;
#(
    parameter int GROUP_DEPTH_P = GROUP_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CHAR_W-1:0] s_text_char,
    input  wire logic              s_end_of_text,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CHAR_W-1:0]      m_data_byte,
    output logic                   m_is_status,
    output logic                   m_failed,
    output logic                   m_last_of_run
);

    // group handoff between the quad builder and the result queue
    logic   grp_push;
    logic   push_ok;
    group_t grp;

    // character decode, quad state, sticky error, end marker handling
    b64d_quad u_quad (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_char   (s_text_char),
        .s_end_of_text (s_end_of_text),
        .push_ok       (push_ok),
        .grp_push      (grp_push),
        .grp           (grp)
    );

    // queue of result groups, split into single byte transfers
    b64d_out #(
        .DEPTH (GROUP_DEPTH_P)
    ) u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .grp_push      (grp_push),
        .grp           (grp),
        .push_ok       (push_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_is_status   (m_is_status),
        .m_failed      (m_failed),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire
